// ===== rtl/pt_pkg.sv =====
// ============================================================================
// pt_pkg: shared types and constants of the pair table
// Capacity, field widths, status codes, state encoding and the search token.
// ============================================================================
`default_nettype none

package pt_pkg;

    localparam int CAPACITY = 256;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int ID_W     = 64;
    localparam int SLOT_W   = 8;
    localparam int LIVE_W   = 9;
    localparam int STAT_W   = 2;

    localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STAT_W-1:0] STAT_RESERVED  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL      = 2'd2;
    localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd3;

    localparam logic REQ_ADD = 1'b0;
    localparam logic REQ_REM = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_RUN,
        S_DONE
    } t_state;

    // Token that walks the row of cells, one cell per cycle.
    typedef struct packed {
        logic             valid;
        logic             is_rem;
        logic [ID_W-1:0]  first;
        logic [ID_W-1:0]  second;
        logic [IDX_W-1:0] pos;
        logic [IDX_W-1:0] slot;
        logic             hit;
    } t_tok;

endpackage

`default_nettype wire

// ===== rtl/pt_cell.sv =====
// ============================================================================
// pt_cell: one slot of the pair table
// Holds a pair and its live bit, acts on the passing token and hands it on.
// ============================================================================
`default_nettype none

module pt_cell (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  pt_pkg::t_tok      i_tok,
    output pt_pkg::t_tok      o_tok
);

    logic [pt_pkg::ID_W-1:0] r_first;
    logic [pt_pkg::ID_W-1:0] r_second;
    logic                    r_live;
    pt_pkg::t_tok            r_tok;
    pt_pkg::t_tok            n_tok;
    logic                    w_here;
    logic                    w_wr;
    logic                    w_match;

    always_comb begin
        w_here  = i_tok.valid && (i_tok.pos == i_tok.slot);
        w_wr    = w_here && !i_tok.is_rem;
        w_match = i_tok.valid && i_tok.is_rem && !i_tok.hit && r_live
                  && (r_first == i_tok.first) && (r_second == i_tok.second);
        n_tok     = i_tok;
        n_tok.pos = i_tok.pos + 1'b1;
        if (w_match) begin
            n_tok.hit  = 1'b1;
            n_tok.slot = i_tok.pos;
        end
    end

    // Only the live bit and the token's valid bit are reset; the rest of the
    // token and the stored pair simply follow.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live      <= 1'b0;
            r_tok.valid <= 1'b0;
        end else begin
            r_tok.valid <= n_tok.valid;
            if (w_wr) begin
                r_live <= 1'b1;
            end else if (w_match) begin
                r_live <= 1'b0;
            end
        end
        r_tok.is_rem <= n_tok.is_rem;
        r_tok.first  <= n_tok.first;
        r_tok.second <= n_tok.second;
        r_tok.pos    <= n_tok.pos;
        r_tok.slot   <= n_tok.slot;
        r_tok.hit    <= n_tok.hit;
        if (w_wr) begin
            r_first  <= i_tok.first;
            r_second <= i_tok.second;
        end
    end

    assign o_tok = r_tok;

endmodule

`default_nettype wire

// ===== rtl/pair_table_with_slot_reuse.sv =====
// ============================================================================
// pair_table_with_slot_reuse: pair table with a last-in first-out free list
// Stores id pairs in a row of cells; adds reuse freed slots, removes search.
// ============================================================================
//
//  Channel   Direction  Carries
//  s_axis    in         request item: tuser = kind, tdata = ids and time
//  m_axis    out        result item: status, slot, live count, last change
//  APB       in/out     register 0 (reserved_id), 64 bits at address 0
//
// An accepted request goes through the reserved and full checks in S_CHECK.
// One that passes them sends a token down the row of CAPACITY cells, one cell
// per clock; when the token leaves the last cell the request moves to S_DONE,
// its result is loaded into the output register once that is free, and the
// next item is taken back in S_IDLE. A rejected request goes from the checks
// straight to S_DONE. Reset is synchronous and clears the live bits, counters
// and handshake state; no clearing pass is needed.
// A result waits in the output register while the next item is accepted; if
// it is still waiting when that item finishes, the item holds in its last
// state and the input stays closed until the result leaves.
//
`default_nettype none

module pair_table_with_slot_reuse (
    input  wire           i_clk,
    input  wire           i_rst_n,
    // Request: [63:0] first_id, [127:64] second_id, [191:128] now_time
    input  wire  [191:0]  s_axis_tdata,
    // Request kind: [0] req_type
    input  wire  [0:0]    s_axis_tuser,
    input  wire           s_axis_tvalid,
    output logic          s_axis_tready,
    // Result: [1:0] status, [9:2] slot_index, [18:10] live_count,
    // [82:19] last_modified, [87:83] zero
    output logic [87:0]   m_axis_tdata,
    output logic          m_axis_tvalid,
    input  wire           m_axis_tready,
    input  wire           psel,
    input  wire           penable,
    input  wire           pwrite,
    input  wire  [0:0]    paddr,
    input  wire  [63:0]   pwdata,
    output logic [63:0]   prdata,
    output logic          pready
);

    localparam int CAP   = pt_pkg::CAPACITY;
    localparam int IDX_W = pt_pkg::IDX_W;
    localparam int CNT_W = pt_pkg::CNT_W;
    localparam int ID_W  = pt_pkg::ID_W;

    pt_pkg::t_state r_state, n_state;

    logic [ID_W-1:0]   r_reserved;
    logic              r_kind;
    logic [ID_W-1:0]   r_first, r_second, r_now;
    logic [CNT_W-1:0]  r_used, r_holes;
    logic [ID_W-1:0]   r_modified;
    logic [pt_pkg::STAT_W-1:0] r_status;
    logic [IDX_W-1:0]  r_slot;
    logic              r_from_hole;
    logic              r_out_valid;
    logic [87:0]       r_out_data;

    // Free-slot stack with a registered read port.
    logic [IDX_W-1:0]  r_stack [CAP];
    logic [IDX_W-1:0]  r_stack_q;
    logic [IDX_W-1:0]  w_rd_addr;
    logic [IDX_W-1:0]  w_wr_addr;
    logic              w_push;

    pt_pkg::t_tok      w_tok [CAP+1];

    logic              w_accept;
    logic              w_reserved_hit;
    logic              w_full;
    logic              w_launch;
    logic              w_load;
    logic [CNT_W-1:0]  w_live;

    assign pready        = 1'b1;
    assign prdata        = r_reserved;
    assign s_axis_tready = (r_state == pt_pkg::S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    assign w_rd_addr = IDX_W'(r_holes - 1'b1);
    assign w_wr_addr = IDX_W'(r_holes);

    always_comb begin
        w_reserved_hit = (r_first == r_reserved) || (r_second == r_reserved);
        w_full   = (r_holes == '0) && (r_used == CNT_W'(CAP));
        w_launch = (r_state == pt_pkg::S_CHECK) && !w_reserved_hit
                   && !(r_kind == pt_pkg::REQ_ADD && w_full);
        w_load   = (r_state == pt_pkg::S_DONE) && (!r_out_valid || m_axis_tready);
        w_push   = w_load && (r_status == pt_pkg::STAT_OK)
                   && (r_kind == pt_pkg::REQ_REM);
        n_state  = r_state;
        case (r_state)
            pt_pkg::S_IDLE:  if (w_accept) n_state = pt_pkg::S_CHECK;
            pt_pkg::S_CHECK: n_state = w_launch ? pt_pkg::S_RUN : pt_pkg::S_DONE;
            pt_pkg::S_RUN:   if (w_tok[CAP].valid) n_state = pt_pkg::S_DONE;
            pt_pkg::S_DONE:  if (w_load) n_state = pt_pkg::S_IDLE;
            default:         n_state = pt_pkg::S_IDLE;
        endcase
    end

    // Token entering the first cell.
    always_comb begin
        w_tok[0].valid  = w_launch;
        w_tok[0].is_rem = (r_kind == pt_pkg::REQ_REM);
        w_tok[0].first  = r_first;
        w_tok[0].second = r_second;
        w_tok[0].pos    = '0;
        w_tok[0].slot   = (r_holes != '0) ? r_stack_q : IDX_W'(r_used);
        w_tok[0].hit    = 1'b0;
    end

    for (genvar g = 0; g < CAP; g++) begin : g_cell
        pt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_tok   (w_tok[g]),
            .o_tok   (w_tok[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        r_stack_q <= r_stack[w_rd_addr];
        if (w_push) begin
            r_stack[w_wr_addr] <= r_slot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pt_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Counters after this request, as reported in the result.
    always_comb begin
        w_live = r_used - r_holes;
        if (r_status == pt_pkg::STAT_OK) begin
            if (r_kind == pt_pkg::REQ_REM) begin
                w_live = r_used - r_holes - 1'b1;
            end else if (r_from_hole) begin
                w_live = r_used - r_holes + 1'b1;
            end else begin
                w_live = r_used + 1'b1 - r_holes;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reserved  <= '0;
            r_used      <= '0;
            r_holes     <= '0;
            r_modified  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (psel && penable && pwrite && (paddr == 1'b0)) begin
                r_reserved <= pwdata;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
                if (r_status == pt_pkg::STAT_OK) begin
                    r_modified <= r_now;
                    if (r_kind == pt_pkg::REQ_REM) begin
                        r_holes <= r_holes + 1'b1;
                    end else if (r_from_hole) begin
                        r_holes <= r_holes - 1'b1;
                    end else begin
                        r_used <= r_used + 1'b1;
                    end
                end
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_kind   <= s_axis_tuser[0];
            r_first  <= s_axis_tdata[63:0];
            r_second <= s_axis_tdata[127:64];
            r_now    <= s_axis_tdata[191:128];
        end
        if (r_state == pt_pkg::S_CHECK) begin
            r_from_hole <= (r_holes != '0);
            r_slot      <= w_tok[0].slot;
            if (w_reserved_hit) begin
                r_status <= pt_pkg::STAT_RESERVED;
            end else if (r_kind == pt_pkg::REQ_ADD && w_full) begin
                r_status <= pt_pkg::STAT_FULL;
            end else begin
                r_status <= pt_pkg::STAT_OK;
            end
        end
        if ((r_state == pt_pkg::S_RUN) && w_tok[CAP].valid && w_tok[CAP].is_rem) begin
            r_status <= w_tok[CAP].hit ? pt_pkg::STAT_OK : pt_pkg::STAT_NOT_FOUND;
            r_slot   <= w_tok[CAP].slot;
        end
        if (w_load) begin
            r_out_data[1:0]   <= r_status;
            r_out_data[9:2]   <= (r_status == pt_pkg::STAT_OK)
                                 ? pt_pkg::SLOT_W'(r_slot) : '0;
            r_out_data[18:10] <= pt_pkg::LIVE_W'(w_live);
            r_out_data[82:19] <= (r_status == pt_pkg::STAT_OK) ? r_now : r_modified;
            r_out_data[87:83] <= '0;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/pt_chk.sv =====
// ============================================================================
// pt_chk: port-level checks of the pair table
// Watches the result channel and the request handshake over time.
// ============================================================================
`default_nettype none

module pt_chk (
    input wire         i_clk,
    input wire         i_rst_n,
    input wire         s_axis_tvalid,
    input wire         s_axis_tready,
    input wire [87:0]  m_axis_tdata,
    input wire         m_axis_tvalid,
    input wire         m_axis_tready
);

    // A stalled result keeps its value.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // A failed request never names a slot.
    a_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[1:0] != 2'd0) |-> m_axis_tdata[9:2] == 8'd0)
        else $error("slot given with failure status");

    // One request at a time: no item is taken right after another.
    a_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request taken while busy");

    // The padding bits of a result stay zero.
    a_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[87:83] == 5'd0)
        else $error("result padding not zero");

endmodule

bind pair_table_with_slot_reuse pt_chk u_pt_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
);

`default_nettype wire
